### rtl/core/gyro_bias_still_calibrator_macros.svh
// assertion macros for the calibrator rtl
`ifndef GYRO_BIAS_STILL_CALIBRATOR_MACROS_SVH
`define GYRO_BIAS_STILL_CALIBRATOR_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define GBSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/gbsc_pkg.sv
// types, constants and helpers for the gyro bias calibrator
package gbsc_pkg;

   localparam int RING_DEPTH = 100;
   localparam int RING_PTR_W = $clog2(RING_DEPTH);
   localparam int RING_CNT_W = $clog2(RING_DEPTH + 1);

   localparam int TIME_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int CORR_W   = SAMPLE_W + 1;
   localparam int CHANGE_W = SAMPLE_W + 2;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 3 * CORR_W;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] THRESHOLD_RESET = 16'd25;
   localparam logic [15:0] SETTLE_RESET    = 16'd2000;
   localparam logic [7:0]  DIVIDER_RESET   = 8'd10;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STILL_THRESHOLD = 2'd0,
      CSR_SETTLE_MS       = 2'd1,
      CSR_DIVIDER_MS      = 2'd2
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [RING_PTR_W-1:0] ring_ptr_type;

   typedef struct packed {
      sample_type z;
      sample_type y;
      sample_type x;
   } axes_type;

   typedef struct packed {
      logic         en;
      ring_ptr_type addr;
      axes_type     data;
   } ring_wr_type;

   function automatic ring_ptr_type ring_inc(input ring_ptr_type ptr);
      ring_ptr_type nxt;
      if (ptr == RING_PTR_W'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   function automatic logic [SAMPLE_W-1:0] abs_diff(input sample_type a, input sample_type b);
      logic signed [SAMPLE_W:0] d;
      logic        [SAMPLE_W:0] m;
      d = CORR_W'(a) - CORR_W'(b);
      m = d[SAMPLE_W] ? -d : d;
      return m[SAMPLE_W-1:0];
   endfunction

endpackage

### rtl/core/gbsc_ring.sv
// ring buffer of still samples with one registered read port
module gbsc_ring (
   input  logic                  clock,
   input  gbsc_pkg::ring_wr_type wr,
   input  gbsc_pkg::ring_ptr_type rd_addr,
   output gbsc_pkg::axes_type    rd_data
);
   import gbsc_pkg::*;

   axes_type ring_mem [RING_DEPTH];
   axes_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ring_mem[wr.addr] <= wr.data;
      end
   end

   // write-first when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/gyro_bias_still_calibrator.sv
// gyro zero-rate bias calibrator: still detection, bias capture and correction
// path: input stage register, then result register (results only once calibrated)
// throughput: one sample per cycle unless the result side stalls; the ring read
//   is fetched ahead so back-to-back captures never wait on the memory port
// reset: synchronous, clears config to defaults and all control and bias state;
//   ring contents stay undefined and are never read before being written
`include "gyro_bias_still_calibrator_macros.svh"

module gyro_bias_still_calibrator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // time_ms[31:0], gyro_x[47:32], gyro_y[63:48], gyro_z[79:64]
   input  logic [gbsc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // corr_x[16:0], corr_y[33:17], corr_z[50:34], zero pad above
   output logic [gbsc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [gbsc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gbsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import gbsc_pkg::*;

   // configuration
   logic [15:0] threshold_ff;
   logic [15:0] settle_ff;
   logic [7:0]  divider_ff;

   // input stage
   logic               s1_valid_ff, s1_valid_in;
   logic [TIME_W-1:0]  s1_time_ff;
   axes_type           s1_gyro_ff;
   logic               s1_fire;
   logic               out_free;

   // calibration state
   logic [TIME_W-1:0]     last_pass_ff, last_pass_in;
   logic [TIME_W-1:0]     still_since_ff, still_since_in;
   axes_type              prev_gyro_ff, prev_gyro_in;
   logic                  calibrated_ff, calibrated_in;
   axes_type              bias_ff, bias_in;
   ring_ptr_type          ring_pos_ff, ring_pos_in;
   logic [RING_CNT_W-1:0] ring_fill_ff, ring_fill_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CORR_W-1:0] corr_x_ff, corr_y_ff, corr_z_ff;
   logic signed [CORR_W-1:0] corr_x, corr_y, corr_z;

   // pass logic
   logic [TIME_W-1:0]   elapsed;
   logic                pass;
   logic [CHANGE_W-1:0] change;
   logic                still;
   logic [TIME_W-1:0]   since_eff;
   logic [TIME_W-1:0]   settled;
   logic                capture;

   ring_wr_type  ring_wr;
   ring_ptr_type ring_rd_addr;
   axes_type     ring_rd_data;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         settle_ff    <= SETTLE_RESET;
         divider_ff   <= DIVIDER_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STILL_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_SETTLE_MS:       settle_ff    <= csr_wdata;
            CSR_DIVIDER_MS:      divider_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- input stage ----------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_time_ff   <= req_tdata[31:0];
         s1_gyro_ff.x <= req_tdata[47:32];
         s1_gyro_ff.y <= req_tdata[63:48];
         s1_gyro_ff.z <= req_tdata[79:64];
      end
   end

   // ---------------- calibration pass ----------------
   assign elapsed = s1_time_ff - last_pass_ff;
   assign pass    = elapsed >= TIME_W'(divider_ff);

   assign change = CHANGE_W'(abs_diff(s1_gyro_ff.x, prev_gyro_ff.x))
                 + CHANGE_W'(abs_diff(s1_gyro_ff.y, prev_gyro_ff.y))
                 + CHANGE_W'(abs_diff(s1_gyro_ff.z, prev_gyro_ff.z));
   assign still  = change < CHANGE_W'(threshold_ff);

   // a zero mark means stillness has not started yet
   assign since_eff = (still_since_ff == '0) ? s1_time_ff : still_since_ff;
   assign settled   = s1_time_ff - since_eff;
   assign capture   = s1_fire && pass && still && (settled > TIME_W'(settle_ff));

   always_comb begin
      last_pass_in   = last_pass_ff;
      still_since_in = still_since_ff;
      prev_gyro_in   = prev_gyro_ff;
      calibrated_in  = calibrated_ff;
      bias_in        = bias_ff;
      ring_pos_in    = ring_pos_ff;
      ring_fill_in   = ring_fill_ff;
      ring_wr.en     = 1'b0;
      ring_wr.addr   = ring_pos_ff;
      ring_wr.data   = s1_gyro_ff;

      if (s1_fire && pass) begin
         last_pass_in   = s1_time_ff;
         prev_gyro_in   = s1_gyro_ff;
         still_since_in = still ? since_eff : s1_time_ff;
      end

      if (capture) begin
         if (!calibrated_ff) begin
            calibrated_in = 1'b1;
            bias_in       = s1_gyro_ff;
         end else begin
            ring_wr.en  = 1'b1;
            ring_pos_in = ring_inc(ring_pos_ff);
            if (ring_fill_ff < RING_CNT_W'(RING_DEPTH)) begin
               ring_fill_in = ring_fill_ff + 1'b1;
            end else begin
               // read data holds the entry just after the write slot: the oldest one kept
               bias_in = ring_rd_data;
            end
         end
      end
   end

   // fetch the entry after the next write slot ahead of its use
   assign ring_rd_addr = ring_inc(ring_pos_in);

   gbsc_ring u_ring (
      .clock   (clock),
      .wr      (ring_wr),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pass_ff   <= '0;
         still_since_ff <= '0;
         prev_gyro_ff   <= '0;
         calibrated_ff  <= 1'b0;
         bias_ff        <= '0;
         ring_pos_ff    <= '0;
         ring_fill_ff   <= '0;
      end else begin
         last_pass_ff   <= last_pass_in;
         still_since_ff <= still_since_in;
         prev_gyro_ff   <= prev_gyro_in;
         calibrated_ff  <= calibrated_in;
         bias_ff        <= bias_in;
         ring_pos_ff    <= ring_pos_in;
         ring_fill_ff   <= ring_fill_in;
      end
   end

   // ---------------- result register ----------------
   assign corr_x = CORR_W'(s1_gyro_ff.x) - CORR_W'(bias_ff.x);
   assign corr_y = CORR_W'(s1_gyro_ff.y) - CORR_W'(bias_ff.y);
   assign corr_z = CORR_W'(s1_gyro_ff.z) - CORR_W'(bias_ff.z);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_fire && calibrated_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && calibrated_ff) begin
         corr_x_ff <= corr_x;
         corr_y_ff <= corr_y;
         corr_z_ff <= corr_z;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, corr_z_ff, corr_y_ff, corr_x_ff};

   // ---------------- checks ----------------
   `GBSC_ASSERT_NEXT(a_cal_sticky, calibrated_ff, calibrated_ff, "calibration flag dropped")
   `GBSC_ASSERT_NEXT(a_bias_hold, !capture, $stable(bias_ff), "bias moved without a capture")
   `GBSC_ASSERT_NOW(a_fill_pos, ring_fill_ff < RING_CNT_W'(RING_DEPTH),
                    ring_fill_ff == RING_CNT_W'(ring_pos_ff), "ring position lost track of fill")
   `GBSC_ASSERT_NOW(a_rsp_cal, s1_fire && !calibrated_ff && !rsp_valid_ff, !rsp_valid_in,
                    "result raised before calibration")

endmodule

### test/gbsc_checker.sv
// bias calibrator checker: predicts corrected samples and compares every result beat
`timescale 1ns / 100ps

module gbsc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // time_ms[31:0], gyro_x[47:32], gyro_y[63:48], gyro_z[79:64]
   input  logic [gbsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // corr_x[16:0], corr_y[33:17], corr_z[50:34], zero pad above
   input  logic [gbsc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_we,
   input  logic [gbsc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [gbsc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned                      corr_pending,
   output int unsigned                      error_count,
   output int unsigned                      checked_count,
   output int unsigned                      capture_count
);
   import gbsc_pkg::*;

   typedef struct packed {
      logic signed [CORR_W-1:0] z;
      logic signed [CORR_W-1:0] y;
      logic signed [CORR_W-1:0] x;
   } corr_type;

   corr_type corrected_q[$];

   logic [15:0] still_limit;
   logic [15:0] settle_limit;
   logic [7:0]  pass_gap;

   logic [TIME_W-1:0] last_pass;
   logic [TIME_W-1:0] still_mark;
   axes_type          prev_rate;
   axes_type          bias_rate;
   logic              have_bias;
   axes_type          ring_mem[RING_DEPTH];
   int                ring_wr;
   int                ring_cnt;

   function automatic logic [CHANGE_W-1:0] axis_change(input sample_type a, input sample_type b);
      int d;
      d = int'(a) - int'(b);
      if (d < 0) begin
         d = -d;
      end
      return CHANGE_W'(d);
   endfunction

   task automatic predict_sample(input logic [REQ_TDATA_W-1:0] beat);
      logic [TIME_W-1:0]   now;
      logic [TIME_W-1:0]   since_pass;
      logic [CHANGE_W-1:0] change;
      axes_type            g;
      corr_type            c;
      now = beat[31:0];
      g.x = beat[47:32];
      g.y = beat[63:48];
      g.z = beat[79:64];
      // correction uses the bias held before this sample's own pass
      if (have_bias) begin
         c.x = $signed(g.x) - $signed(bias_rate.x);
         c.y = $signed(g.y) - $signed(bias_rate.y);
         c.z = $signed(g.z) - $signed(bias_rate.z);
         corrected_q.push_back(c);
      end
      since_pass = now - last_pass;
      if (since_pass < TIME_W'(pass_gap)) begin
         return;
      end
      last_pass = now;
      change = axis_change(g.x, prev_rate.x) + axis_change(g.y, prev_rate.y)
             + axis_change(g.z, prev_rate.z);
      prev_rate = g;
      // zero mark means stillness not started yet
      if (still_mark == '0) begin
         still_mark = now;
      end
      if (change < CHANGE_W'(still_limit)) begin
         if (TIME_W'(now - still_mark) > TIME_W'(settle_limit)) begin
            capture_count++;
            if (!have_bias) begin
               have_bias = 1'b1;
               bias_rate = g;
            end else begin
               ring_mem[ring_wr] = g;
               ring_wr = (ring_wr == RING_DEPTH - 1) ? 0 : ring_wr + 1;
               // once full, the oldest entry becomes the bias
               if (ring_cnt < RING_DEPTH) begin
                  ring_cnt++;
               end else begin
                  bias_rate = ring_mem[ring_wr];
               end
            end
         end
      end else begin
         still_mark = now;
      end
   endtask

   task automatic check_corrected(input logic [RSP_TDATA_W-1:0] beat);
      corr_type want;
      corr_type got;
      got.x = beat[16:0];
      got.y = beat[33:17];
      got.z = beat[50:34];
      checked_count++;
      if (corrected_q.size() == 0) begin
         if (error_count < 10) begin
            $display("[%0t] result beat with nothing pending: got x=%0d y=%0d z=%0d",
                     $time, got.x, got.y, got.z);
         end
         error_count++;
      end else begin
         want = corrected_q.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
            if (error_count < 10) begin
               $display("[%0t] corrected sample mismatch: want x=%0d y=%0d z=%0d",
                        $time, want.x, want.y, want.z);
               $display("   got x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            end
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         still_limit   = THRESHOLD_RESET;
         settle_limit  = SETTLE_RESET;
         pass_gap      = DIVIDER_RESET;
         last_pass     = '0;
         still_mark    = '0;
         prev_rate     = '0;
         bias_rate     = '0;
         have_bias     = 1'b0;
         ring_wr       = 0;
         ring_cnt      = 0;
         error_count   = 0;
         checked_count = 0;
         capture_count = 0;
         corrected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_STILL_THRESHOLD: still_limit = csr_wdata;
               CSR_SETTLE_MS:       settle_limit = csr_wdata;
               CSR_DIVIDER_MS:      pass_gap = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_sample(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_corrected(rsp_tdata);
         end
      end
      corr_pending <= corrected_q.size();
   end

endmodule

### test/tb_top.sv
// testbench top for the gyro bias calibrator: stimulus, pacing and verdict
`timescale 1ns / 100ps

module tb_top;
   import gbsc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned corr_pending;
   int unsigned error_count;
   int unsigned checked_count;
   int unsigned capture_count;

   int unsigned cycle_count = 0;
   int unsigned sample_count = 0;
   int unsigned setting_count = 0;
   int unsigned rsp_stall = 0;
   bit          src_idle_on = 1'b1;
   bit          sink_idle_on = 1'b1;

   // state of the random sample stream
   logic [TIME_W-1:0] stream_ms = '0;
   int                base_x = 0;
   int                base_y = 0;
   int                base_z = 0;
   int unsigned       step_max = 1;

   gyro_bias_still_calibrator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   gbsc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .corr_pending  (corr_pending),
      .error_count   (error_count),
      .checked_count (checked_count),
      .capture_count (capture_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycle_count, corr_pending);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // result side: after each beat, hold ready low for a randomly drawn stall, if sink pacing is on
   always @(posedge clock) begin : sink_pace
      int unsigned w;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_stall != 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else if (!rsp_tready || rsp_tvalid) begin
         w = sink_idle_on ? $urandom_range(0, 3) : 0;
         rsp_stall  <= w;
         rsp_tready <= (w == 0);
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_sample(input logic [TIME_W-1:0] t,
                                                          input sample_type x,
                                                          input sample_type y,
                                                          input sample_type z);
      return {z, y, x, t};
   endfunction

   function automatic sample_type clamp_rate(input int v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return sample_type'(v);
   endfunction

   task automatic send_sample(input logic [REQ_TDATA_W-1:0] beat);
      int unsigned gap;
      gap = src_idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      sample_count++;
   endtask

   // sender pauses until every pending result is back, then covers the pipeline
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (corr_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [15:0] thr, input logic [15:0] settle,
                                input logic [7:0] div);
      wait_for_results();
      write_csr(CSR_STILL_THRESHOLD, thr);
      write_csr(CSR_SETTLE_MS, settle);
      write_csr(CSR_DIVIDER_MS, CSR_DATA_W'(div));
      csr_we <= 1'b0;
      @(posedge clock);
      setting_count++;
   endtask

   // mostly still plateaus with small jitter, and some motion, junk and time jumps
   task automatic next_random_sample(output logic [REQ_TDATA_W-1:0] beat);
      int unsigned roll;
      sample_type  gx;
      sample_type  gy;
      sample_type  gz;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         stream_ms = $urandom();
         gx = sample_type'($urandom());
         gy = sample_type'($urandom());
         gz = sample_type'($urandom());
      end else begin
         stream_ms = stream_ms + $urandom_range(0, step_max);
         if (roll < 75) begin
            gx = clamp_rate(base_x + int'($urandom_range(0, 4)) - 2);
            gy = clamp_rate(base_y + int'($urandom_range(0, 4)) - 2);
            gz = clamp_rate(base_z + int'($urandom_range(0, 4)) - 2);
         end else if (roll < 90) begin
            base_x = int'(sample_type'($urandom()));
            base_y = int'(sample_type'($urandom()));
            base_z = int'(sample_type'($urandom()));
            gx = sample_type'(base_x);
            gy = sample_type'(base_y);
            gz = sample_type'(base_z);
         end else begin
            gx = sample_type'($urandom());
            gy = sample_type'($urandom());
            gz = sample_type'($urandom());
         end
      end
      beat = pack_sample(stream_ms, gx, gy, gz);
   endtask

   task automatic run_phase(input logic [15:0] thr, input logic [15:0] settle,
                            input logic [7:0] div, input int unsigned count,
                            input int unsigned step);
      logic [REQ_TDATA_W-1:0] beat;
      apply_setting(thr, settle, div);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on <= ($urandom_range(0, 3) != 0);
      step_max = step;
      for (int unsigned n = 0; n < count; n++) begin
         if (n == count / 2) begin
            wait_for_results();
         end
         next_random_sample(beat);
         send_sample(beat);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: threshold 25, settle 2000, divider 10
      send_sample(pack_sample(32'd3, 16'sd0, 16'sd0, 16'sd0));       // below divider after reset
      send_sample(pack_sample(32'd10, 16'sd1, 16'sd0, -16'sd1));     // first pass, starts stillness
      send_sample(pack_sample(32'd2010, 16'sd1, 16'sd1, -16'sd1));   // settle exactly reached
      send_sample(pack_sample(32'd2020, 16'sd1, 16'sd1, -16'sd1));   // first capture sets bias
      send_sample(pack_sample(32'd2025, 16'sh7FFF, 16'sh8000, 16'sd0));
      send_sample(pack_sample(32'd2030, 16'sh8000, 16'sh7FFF, 16'sh8000));
      send_sample(pack_sample(32'd2040, 16'sh8000, 16'sh7FFF, 16'sh8000));
      send_sample(pack_sample(32'hFFFF_FF00, 16'sh8000, 16'sh7FFF, 16'sh8000));
      send_sample(pack_sample(32'h0000_0040, 16'sh8000, 16'sh7FFF, 16'sh8000)); // time wrap
      send_sample(pack_sample(32'h0000_0050, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
      send_sample(pack_sample(32'h0000_0060, 16'sh7FFE, 16'sh7FFF, 16'sh7FFF));
      send_sample(pack_sample(32'h0000_005A, 16'sh7FFE, 16'sh7FFF, 16'sh7FFF)); // time backwards
      send_sample(pack_sample(32'h0000_0070, 16'sh7FF4, 16'sh7FF5, 16'sh7FFA)); // change equals limit
      send_sample(pack_sample(32'h0000_0080, 16'sh7FFE, 16'sh7FFF, 16'sh7FFE)); // change just under
      send_sample(pack_sample(32'h0000_1000, 16'sh7FFE, 16'sh7FFF, 16'sh7FF3));
      setting_count++;

      // every item passes; motion at time zero leaves stillness unstarted
      apply_setting(16'hFFFF, 16'd0, 8'd0);
      send_sample(pack_sample(32'd0, 16'sh8000, 16'sh8000, 16'sh8000));
      send_sample(pack_sample(32'd5, 16'sh8000, 16'sh8000, 16'sh8000));
      send_sample(pack_sample(32'd6, 16'sh8000, 16'sh8000, 16'sh8000));
      send_sample(pack_sample(32'd6, 16'sh8000, 16'sh8000, 16'sh8001));
      send_sample(pack_sample(32'd7, -16'sd1, 16'sd0, 16'sd1));

      run_phase(16'd40, 16'd0, 8'd0, 350, 3);
      run_phase(16'd0, 16'd100, 8'd1, 120, 5);
      run_phase(16'hFFFF, 16'hFFFF, 8'hFF, 150, 400);
      repeat (6) begin
         run_phase(16'($urandom_range(1, 300)), 16'($urandom_range(0, 400)),
                   8'($urandom_range(0, 30)), 150, $urandom_range(1, 40));
      end
      run_phase(THRESHOLD_RESET, SETTLE_RESET, DIVIDER_RESET, 150, 50);

      wait_for_results();
      repeat (6) @(posedge clock);

      $display("sent %0d samples across %0d register settings", sample_count, setting_count);
      $display("checked %0d corrected samples; %0d bias captures predicted",
               checked_count, capture_count);
      if (error_count == 0 && corr_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results never arrived", error_count, corr_pending);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### gyro_bias_still_calibrator.f
+incdir+rtl/core
rtl/core/gbsc_pkg.sv
rtl/core/gbsc_ring.sv
rtl/core/gyro_bias_still_calibrator.sv
test/gbsc_checker.sv
test/tb_top.sv
